>>> rtl/core/bnu_pkg.sv
// Shared constants for the batch normalization unit.
`default_nettype none
package bnu_pkg;
    localparam int DATA_BITS = 16;
    localparam int CHAN_W    = 6;
    localparam int FUNC_W    = 2;
    localparam int SUM_W     = 32;
    localparam int SQ_W      = 48;
    localparam int VAR_W     = 24;
    localparam int DIV_W     = 48;
    localparam int RAD_W     = 42;
    localparam int ROOT_W    = 21;
    localparam int REM_W     = 24;
    localparam int Q_W       = 41;

    localparam logic [FUNC_W-1:0] FUNC_LOAD  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_ACCUM = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_NORM  = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd3;

    localparam logic [1:0] CFG_TRAINING = 2'd0;
    localparam logic [1:0] CFG_EPSILON  = 2'd1;
    localparam logic [1:0] CFG_COUNT    = 2'd2;

    localparam logic [15:0] EPS_RESET = 16'd66;
endpackage
`default_nettype wire

>>> rtl/core/batch_normalization_unit.sv
// Load, clear: handled as the item is taken. Accumulate: read-modify-write of the statistics RAM.
// Normalize in inference mode: a multiply, the 21-step serial root and the 48-step serial
// divider; training mode adds two divider passes before them. A new item is taken while
// the result register still waits; a finished result that finds it full holds the unit
// until it drains. Synchronous active-low reset clears control, config and statistics
// valid bits; coefficient tables start undefined.
`default_nettype none
module batch_normalization_unit import bnu_pkg::*; #(
    parameter int MAX_CHANNELS = 64,
    parameter int COUNT_BITS   = 16,
    localparam int CFG_W       = (COUNT_BITS > 16) ? COUNT_BITS : 16
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    // channel[5:0], sample[21:6], coef_scale[37:22], coef_bias[53:38],
    // coef_mean[69:54], coef_var[85:70], zero fill
    input  wire logic [87:0]       s_tdata,
    // func[1:0]
    input  wire logic [1:0]        s_tuser,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    // normalized[15:0]
    output logic      [15:0]       m_tdata,
    // saturated[0]
    output logic      [0:0]        m_tuser,
    input  wire logic              cfg_wr_en,
    input  wire logic [1:0]        cfg_index,
    input  wire logic [CFG_W-1:0]  cfg_wdata
);
    localparam int AW    = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int DVW   = (COUNT_BITS > ROOT_W) ? COUNT_BITS : ROOT_W;

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_ACC_RD  = 4'd1;
    localparam logic [3:0] ST_ACC_WR  = 4'd2;
    localparam logic [3:0] ST_RD      = 4'd3;
    localparam logic [3:0] ST_LATCH   = 4'd4;
    localparam logic [3:0] ST_DIV_SUM = 4'd5;
    localparam logic [3:0] ST_DIV_SQ  = 4'd6;
    localparam logic [3:0] ST_MUL     = 4'd7;
    localparam logic [3:0] ST_SQRT    = 4'd8;
    localparam logic [3:0] ST_DIV_Q   = 4'd9;
    localparam logic [3:0] ST_OUT     = 4'd10;

    // config
    logic                  training_reg;
    logic [15:0]           eps_reg;
    logic [COUNT_BITS-1:0] count_reg;
    logic [COUNT_BITS-1:0] n_val;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            training_reg <= 1'b0;
            eps_reg      <= EPS_RESET;
            count_reg    <= COUNT_BITS'(1);
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_TRAINING: training_reg <= cfg_wdata[0];
                CFG_EPSILON:  eps_reg      <= cfg_wdata[15:0];
                CFG_COUNT:    count_reg    <= cfg_wdata[COUNT_BITS-1:0];
                default: ;
            endcase
        end
    end

    assign n_val = (count_reg == '0) ? COUNT_BITS'(1) : count_reg;

    // input fields
    logic [FUNC_W-1:0] in_func;
    logic [CHAN_W-1:0] in_chan;
    logic [15:0]       in_sample;
    logic              in_hit;
    logic              ch_ok;

    assign in_func   = s_tuser;
    assign in_chan   = s_tdata[5:0];
    assign in_sample = s_tdata[21:6];
    assign in_hit    = s_tvalid && s_tready;
    assign ch_ok     = (int'(in_chan) < MAX_CHANNELS);

    logic [3:0]                state_reg;
    logic [3:0]                state_next;
    logic [AW-1:0]             ch_reg;
    logic signed [15:0]        x_reg;
    logic [31:0]               xx_reg;
    logic [MAX_CHANNELS-1:0]   valid_reg;

    // coefficient table: {var, mean, bias, scale}
    logic [63:0] coef_rdata;
    bnu_ram #(.WIDTH(64), .DEPTH(MAX_CHANNELS)) u_coef_ram (
        .aclk  (aclk),
        .we    (in_hit && ch_ok && (in_func == FUNC_LOAD)),
        .waddr (AW'(in_chan)),
        .wdata (s_tdata[85:22]),
        .raddr (ch_reg),
        .rdata (coef_rdata)
    );

    // statistics table: {square sum, sum}
    logic [SQ_W+SUM_W-1:0] stat_rdata;
    logic [SUM_W-1:0]      st_sum;
    logic [SQ_W-1:0]       st_sq;
    logic                  stat_vld;
    logic [SUM_W-1:0]      sum_new;
    logic [SQ_W-1:0]       sq_new;

    assign stat_vld = valid_reg[ch_reg];
    assign st_sum   = stat_vld ? stat_rdata[SUM_W-1:0] : '0;
    assign st_sq    = stat_vld ? stat_rdata[SQ_W+SUM_W-1:SUM_W] : '0;
    assign sum_new  = st_sum + {{(SUM_W-16){x_reg[15]}}, x_reg};
    assign sq_new   = st_sq + {{(SQ_W-32){1'b0}}, xx_reg};

    bnu_ram #(.WIDTH(SQ_W+SUM_W), .DEPTH(MAX_CHANNELS)) u_stat_ram (
        .aclk  (aclk),
        .we    (state_reg == ST_ACC_WR),
        .waddr (ch_reg),
        .wdata ({sq_new, sum_new}),
        .raddr (ch_reg),
        .rdata (stat_rdata)
    );

    // valid bits: a cleared or never-written channel reads as zero sums
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (state_reg == ST_ACC_WR) begin
            valid_reg[ch_reg] <= 1'b1;
        end else if (in_hit && ch_ok && (in_func == FUNC_CLEAR)) begin
            valid_reg[AW'(in_chan)] <= 1'b0;
        end
    end

    // shared serial units
    logic             div_start;
    logic [DIV_W-1:0] div_dvd;
    logic [DVW-1:0]   div_dvs;
    logic             div_done;
    logic [DIV_W-1:0] div_q;
    logic             sq_start;
    logic [RAD_W-1:0] sq_rad;
    logic             sq_done;
    logic [ROOT_W-1:0] sq_root;

    bnu_div #(.DVW(DVW)) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .done     (div_done),
        .quotient (div_q)
    );

    bnu_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sq_start),
        .radicand (sq_rad),
        .done     (sq_done),
        .root     (sq_root)
    );

    // normalize datapath registers
    logic signed [15:0] scale_reg;
    logic signed [15:0] bias_reg;
    logic signed [15:0] mean_reg;
    logic [VAR_W-1:0]   var_reg;
    logic               sum_neg_reg;
    logic [SQ_W-1:0]    sq_reg;
    logic [31:0]        mm_reg;
    logic signed [32:0] num_reg;
    logic [Q_W-1:0]     q_reg;

    logic [SUM_W-1:0]   sum_abs;
    logic [31:0]        qm;
    logic [15:0]        mean_clamped;
    logic signed [SQ_W:0] var_diff;
    logic [VAR_W-1:0]   var_clamped;
    logic signed [16:0] diff;
    logic [24:0]        v_sum;
    logic [32:0]        num_abs;
    logic [31:0]        mag;
    logic               num_neg;

    always_comb begin
        sum_abs = st_sum[SUM_W-1] ? (~st_sum + 1'b1) : st_sum;
        qm      = div_q[31:0];
        if (sum_neg_reg) begin
            mean_clamped = (qm > 32'd32768) ? 16'h8000 : 16'(~qm + 1'b1);
        end else begin
            mean_clamped = (qm > 32'd32767) ? 16'h7FFF : qm[15:0];
        end
        var_diff = $signed({1'b0, div_q}) - $signed({17'b0, mm_reg});
        if (var_diff < 0) begin
            var_clamped = '0;
        end else if (var_diff > $signed({25'b0, 24'hFFFFFF})) begin
            var_clamped = 24'hFFFFFF;
        end else begin
            var_clamped = var_diff[VAR_W-1:0];
        end
        diff    = {x_reg[15], x_reg} - {mean_reg[15], mean_reg};
        v_sum   = {1'b0, var_reg} + {9'b0, eps_reg};
        num_neg = num_reg[32];
        num_abs = num_neg ? (~num_reg + 1'b1) : num_reg;
        mag     = num_abs[31:0];
    end

    // start strobes and operand selection for the serial units
    always_comb begin
        div_start = 1'b0;
        div_dvd   = {{(DIV_W-SUM_W){1'b0}}, sum_abs};
        div_dvs   = DVW'(n_val);
        sq_start  = (state_reg == ST_MUL);
        sq_rad    = {1'b0, v_sum, 16'b0};
        case (state_reg)
            ST_LATCH: begin
                div_start = training_reg;
            end
            ST_DIV_SUM: begin
                div_start = div_done;
                div_dvd   = sq_reg;
            end
            ST_SQRT: begin
                div_start = sq_done && (sq_root != '0);
                div_dvd   = {8'b0, mag, 8'b0};
                div_dvs   = DVW'(sq_root);
            end
            default: ;
        endcase
    end

    // output stage
    logic               m_valid_reg;
    logic [15:0]        m_data_reg;
    logic               m_sat_reg;
    logic               out_free;
    logic signed [42:0] q_signed;
    logic signed [42:0] y_full;
    logic [15:0]        y_clamped;
    logic               y_sat;

    assign out_free = !m_valid_reg || m_tready;

    always_comb begin
        q_signed = num_neg ? -$signed({2'b0, q_reg}) : $signed({2'b0, q_reg});
        y_full   = q_signed + {{27{bias_reg[15]}}, bias_reg};
        y_sat    = 1'b1;
        if (y_full > 43'sd32767) begin
            y_clamped = 16'h7FFF;
        end else if (y_full < -43'sd32768) begin
            y_clamped = 16'h8000;
        end else begin
            y_clamped = y_full[15:0];
            y_sat     = 1'b0;
        end
    end

    // sequencer
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_hit && ch_ok) begin
                    if (in_func == FUNC_ACCUM) begin
                        state_next = ST_ACC_RD;
                    end else if (in_func == FUNC_NORM) begin
                        state_next = ST_RD;
                    end
                end
            end
            ST_ACC_RD:  state_next = ST_ACC_WR;
            ST_ACC_WR:  state_next = ST_IDLE;
            ST_RD:      state_next = ST_LATCH;
            ST_LATCH:   state_next = training_reg ? ST_DIV_SUM : ST_MUL;
            ST_DIV_SUM: if (div_done) state_next = ST_DIV_SQ;
            ST_DIV_SQ:  if (div_done) state_next = ST_MUL;
            ST_MUL:     state_next = ST_SQRT;
            ST_SQRT: begin
                if (sq_done) begin
                    state_next = (sq_root == '0) ? ST_OUT : ST_DIV_Q;
                end
            end
            ST_DIV_Q:   if (div_done) state_next = ST_OUT;
            ST_OUT:     if (out_free) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_OUT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (in_hit) begin
            ch_reg <= AW'(in_chan);
            x_reg  <= $signed(in_sample);
        end
        if (state_reg == ST_ACC_RD) begin
            xx_reg <= 32'(x_reg * x_reg);
        end
        if (state_reg == ST_LATCH) begin
            scale_reg   <= $signed(coef_rdata[15:0]);
            bias_reg    <= $signed(coef_rdata[31:16]);
            mean_reg    <= $signed(coef_rdata[47:32]);
            var_reg     <= {coef_rdata[63:48], 8'b0};
            sum_neg_reg <= st_sum[SUM_W-1];
            sq_reg      <= st_sq;
        end
        if (state_reg == ST_DIV_SUM && div_done) begin
            mean_reg <= $signed(mean_clamped);
        end
        if (state_reg == ST_DIV_SQ) begin
            mm_reg <= 32'(mean_reg * mean_reg);
            if (div_done) begin
                var_reg <= var_clamped;
            end
        end
        if (state_reg == ST_MUL) begin
            num_reg <= scale_reg * diff;
        end
        if (state_reg == ST_SQRT && sq_done && (sq_root == '0)) begin
            q_reg <= (mag == '0) ? '0 : {1'b1, {(Q_W-1){1'b0}}};
        end
        if (state_reg == ST_DIV_Q && div_done) begin
            q_reg <= div_q[Q_W-1:0];
        end
        if (state_reg == ST_OUT && out_free) begin
            m_data_reg <= y_clamped;
            m_sat_reg  <= y_sat;
        end
    end

    assign s_tready   = (state_reg == ST_IDLE);
    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = m_data_reg;
    assign m_tuser[0] = m_sat_reg;
endmodule
`default_nettype wire

>>> rtl/core/bnu_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module bnu_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                   aclk,
    input  wire logic                   we,
    input  wire logic [AW-1:0]          waddr,
    input  wire logic [WIDTH-1:0]       wdata,
    input  wire logic [AW-1:0]          raddr,
    output logic      [WIDTH-1:0]       rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule
`default_nettype wire

>>> rtl/core/bnu_div.sv
// Bit-serial restoring divider: one quotient bit per cycle.
`default_nettype none
module bnu_div import bnu_pkg::*; #(
    parameter int DVW = 24
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             start,
    input  wire logic [DIV_W-1:0] dividend,
    input  wire logic [DVW-1:0]   divisor,
    output logic                  done,
    output logic      [DIV_W-1:0] quotient
);
    localparam int CNT_W = $clog2(DIV_W + 1);

    logic [DIV_W-1:0] dvd_reg;
    logic [DVW-1:0]   rem_reg;
    logic [DVW-1:0]   dvs_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DVW:0]     rem_sh;
    logic [DVW:0]     rem_sub;
    logic             ge;

    // trial subtract of one bit position
    always_comb begin
        rem_sh  = {rem_reg, dvd_reg[DIV_W-1]};
        rem_sub = rem_sh - {1'b0, dvs_reg};
        ge      = (rem_sh >= {1'b0, dvs_reg});
    end

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DIV_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath: quotient bits shift into the dividend register
    always_ff @(posedge aclk) begin
        if (start) begin
            dvd_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            dvd_reg <= {dvd_reg[DIV_W-2:0], ge};
            rem_reg <= ge ? rem_sub[DVW-1:0] : rem_sh[DVW-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = dvd_reg;
endmodule
`default_nettype wire

>>> rtl/core/bnu_sqrt.sv
// Digit-serial integer square root: two radicand bits per cycle.
`default_nettype none
module bnu_sqrt import bnu_pkg::*; (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              start,
    input  wire logic [RAD_W-1:0]  radicand,
    output logic                   done,
    output logic      [ROOT_W-1:0] root
);
    localparam int CNT_W = $clog2(ROOT_W + 1);

    logic [RAD_W-1:0]  rad_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [REM_W-1:0]  rem_sh;
    logic [REM_W-1:0]  trial;
    logic              ge;

    always_comb begin
        rem_sh = {rem_reg[REM_W-3:0], rad_reg[RAD_W-1 -: 2]};
        trial  = {1'b0, root_reg, 2'b01};
        ge     = (rem_sh >= trial);
    end

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(ROOT_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (start) begin
            rad_reg  <= radicand;
            root_reg <= '0;
            rem_reg  <= '0;
        end else if (busy_reg) begin
            rad_reg  <= {rad_reg[RAD_W-3:0], 2'b00};
            root_reg <= {root_reg[ROOT_W-2:0], ge};
            rem_reg  <= ge ? (rem_sh - trial) : rem_sh;
        end
    end

    assign done = done_reg;
    assign root = root_reg;
endmodule
`default_nettype wire
